### rtl/aunp_pkg.sv
// Shared widths, character codes and digit decode for the ASCII unsigned number parser.
`default_nettype none

package aunp_pkg;

  // Fixed payload widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned DIGIT_W  = 7;

  // Character codes
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;

  // Bases
  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

  // Digit value of a non-alphanumeric character; above every base
  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd99;

  // Value of an alphanumeric character as a digit
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] d;
    d = {1'b0, NOT_DIGIT};
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - CH_ZERO;
    end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      d = c - CH_UP_A + 8'd10;
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/aunp_if.sv
// Valid/ready channel interfaces for character input and parse results.
`default_nettype none

interface aunp_in_if;
  logic                        valid;
  logic                        ready;
  logic [aunp_pkg::CH_W-1:0]   ch;
  logic                        first;

  modport source (output valid, output ch, output first, input ready);
  modport sink   (input valid, input ch, input first, output ready);
endinterface

interface aunp_out_if #(
  parameter int unsigned OFFSET_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic [aunp_pkg::VALUE_W-1:0] value;
  logic [OFFSET_BITS-1:0]       end_offset;

  modport source (output valid, output value, output end_offset, input ready);
  modport sink   (input valid, input value, input end_offset, output ready);
endinterface

`default_nettype wire

### rtl/ascii_unsigned_number_parser_core.sv
// Top level of the ASCII unsigned number parser: input register, parse engine, result register.
`default_nettype none

// Takes one character of a NUL-terminated string per beat (first marks the start of a
// string) and returns the unsigned value and the offset of the first unconsumed character.
// A character is accepted every cycle while results are taken; a full, unaccepted result
// register stalls the input. The beat ending the number is held in the input register,
// and the result register loads when that stage advances. The per-character path is the
// 64-bit by 6-bit multiply-accumulate in the engine. Leading spaces/tabs and one '+' are
// skipped; radix 0 detects 0x (hex), leading 0 (octal) or decimal, radix 16 also skips 0x.
// The radix is sampled on each first beat; the user must write the radix only while the
// block is idle, and the block itself does not enforce this.
module ascii_unsigned_number_parser_core #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          radix_we_i,
  input  wire logic [aunp_pkg::RADIX_W-1:0]  radix_i,
  aunp_in_if.sink                            in_i,
  aunp_out_if.source                         res_o
);

  logic [aunp_pkg::RADIX_W-1:0]  radix_q;
  logic                          s1_valid_q;
  logic [aunp_pkg::CH_W-1:0]     s1_ch_q;
  logic                          s1_first_q;
  logic                          s1_go, in_acc;
  logic                          out_valid_q, out_valid_d;
  logic [aunp_pkg::VALUE_W-1:0]  value_q;
  logic [OFFSET_BITS-1:0]        offset_q;
  logic                          emit;
  logic [aunp_pkg::VALUE_W-1:0]  eng_value;
  logic [OFFSET_BITS-1:0]        eng_offset;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= '0;
    end else if (radix_we_i) begin
      radix_q <= radix_i;
    end
  end

  // Input stage advances whenever the result register is free or being drained
  assign s1_go      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || s1_go;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q    <= in_i.ch;
      s1_first_q <= in_i.first;
    end
  end

  aunp_engine #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_go),
    .ch_i         (s1_ch_q),
    .first_i      (s1_first_q),
    .radix_i      (radix_q),
    .emit_o       (emit),
    .value_o      (eng_value),
    .end_offset_o (eng_offset)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && emit) begin
      value_q  <= eng_value;
      offset_q <= eng_offset;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.value      = value_q;
  assign res_o.end_offset = offset_q;

endmodule

`default_nettype wire

### rtl/aunp_engine.sv
// Parse state machine: blank/sign/prefix handling and digit accumulation, one beat per step.
`default_nettype none

module aunp_engine #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [aunp_pkg::CH_W-1:0]     ch_i,
  input  wire logic                          first_i,
  input  wire logic [aunp_pkg::RADIX_W-1:0]  radix_i,
  output logic                               emit_o,
  output logic [aunp_pkg::VALUE_W-1:0]       value_o,
  output logic [OFFSET_BITS-1:0]             end_offset_o
);

  typedef enum logic [2:0] {
    PH_DONE,
    PH_BLANK,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_e;

  phase_e                          phase_q, phase_d, phase_cur;
  logic [aunp_pkg::VALUE_W-1:0]    acc_q, acc_d, acc_cur, acc_src;
  logic [aunp_pkg::RADIX_W-1:0]    base_q, base_d, base_cur, dig_base;
  logic [OFFSET_BITS-1:0]          pos_q, pos_d, pos_cur, pos_inc;
  logic [aunp_pkg::DIGIT_W-1:0]    digit;
  logic [aunp_pkg::VALUE_W+aunp_pkg::RADIX_W-1:0] prod;
  logic [aunp_pkg::VALUE_W-1:0]    acc_next;
  logic                            do_start, do_digit, is_digit, emit;

  // A first beat restarts the parse from the configured radix
  always_comb begin
    phase_cur = first_i ? PH_BLANK : phase_q;
    acc_cur   = first_i ? '0 : acc_q;
    base_cur  = first_i ? radix_i : base_q;
    pos_cur   = first_i ? '0 : pos_q;
  end

  // Saturating position advance
  assign pos_inc = (&pos_cur) ? pos_cur : pos_cur + 1'b1;
  assign digit   = aunp_pkg::digit_of(ch_i);

  // Phase decode and selection of the base for the digit step
  always_comb begin
    phase_d  = phase_cur;
    acc_d    = acc_cur;
    base_d   = base_cur;
    pos_d    = pos_cur;
    do_start = 1'b0;
    do_digit = 1'b0;
    dig_base = base_cur;
    acc_src  = acc_cur;
    emit     = 1'b0;

    case (phase_cur)
      PH_BLANK: begin
        if (ch_i == aunp_pkg::CH_SPACE || ch_i == aunp_pkg::CH_TAB) begin
          pos_d = pos_inc;
        end else if (ch_i == aunp_pkg::CH_PLUS) begin
          phase_d = PH_SIGNED;
          pos_d   = pos_inc;
        end else begin
          do_start = 1'b1;
        end
      end
      PH_SIGNED: begin
        do_start = 1'b1;
      end
      PH_ZERO: begin
        if (ch_i == aunp_pkg::CH_LO_X || ch_i == aunp_pkg::CH_UP_X) begin
          base_d  = aunp_pkg::BASE_HEX;
          phase_d = PH_DIGITS;
          pos_d   = pos_inc;
        end else begin
          do_digit = 1'b1;
          acc_src  = '0;
          dig_base = (base_cur == aunp_pkg::BASE_AUTO) ? aunp_pkg::BASE_OCT
                                                       : aunp_pkg::BASE_HEX;
        end
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    // First significant character: possible leading zero of a prefix
    if (do_start) begin
      if ((base_cur == aunp_pkg::BASE_AUTO || base_cur == aunp_pkg::BASE_HEX) &&
          ch_i == aunp_pkg::CH_ZERO) begin
        phase_d = PH_ZERO;
        pos_d   = pos_inc;
      end else begin
        do_digit = 1'b1;
        dig_base = (base_cur == aunp_pkg::BASE_AUTO) ? aunp_pkg::BASE_DEC : base_cur;
      end
    end

    // Digit step: accumulate or finish
    if (do_digit) begin
      base_d = dig_base;
      if (is_digit) begin
        phase_d = PH_DIGITS;
        acc_d   = acc_next;
        pos_d   = pos_inc;
      end else begin
        phase_d = PH_DONE;
        acc_d   = acc_src;
        emit    = 1'b1;
      end
    end
  end

  // Multiply-accumulate by a small base, wrapping at 64 bits
  assign is_digit = digit < {1'b0, dig_base};
  assign prod     = {{aunp_pkg::RADIX_W{1'b0}}, acc_src} *
                    {{aunp_pkg::VALUE_W{1'b0}}, dig_base};
  assign acc_next = prod[aunp_pkg::VALUE_W-1:0] +
                    {{(aunp_pkg::VALUE_W-aunp_pkg::DIGIT_W){1'b0}}, digit};

  assign emit_o       = emit;
  assign value_o      = acc_src;
  assign end_offset_o = pos_cur;

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      acc_q   <= '0;
      base_q  <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

### rtl/aunp_checker.sv
// Port-level assertions for the ASCII unsigned number parser and their bind.
`default_nettype none

module aunp_checker #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic [aunp_pkg::CH_W-1:0]    in_ch_i,
  input wire logic                         in_first_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [aunp_pkg::VALUE_W-1:0] out_value_i,
  input wire logic [OFFSET_BITS-1:0]       out_end_offset_i
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
                                    $stable(out_end_offset_i))
    else $error("result beat changed while stalled");

  // Input never stalls unless the result side is backed up
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with free result register");

  // A string that is only a terminator yields zero at offset zero
  a_empty_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_first_i && in_ch_i == '0
      ##1 (!out_valid_i || out_ready_i)
      |=> out_valid_i && out_value_i == '0 && out_end_offset_i == '0)
    else $error("empty string did not give zero result");

endmodule

bind ascii_unsigned_number_parser_core aunp_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_aunp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_ch_i          (in_i.ch),
  .in_first_i       (in_i.first),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .out_value_i      (res_o.value),
  .out_end_offset_i (res_o.end_offset)
);

`default_nettype wire
